### hdl/generational_handle_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle table
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH

// Check a condition at every clock edge.
`define GHT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check a condition in the cycle after a trigger.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants, codes and payload types of the generational handle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ght_pkg;

  // Default table geometry
  localparam int SlotCapacity = 1024;
  localparam int GenBits      = 24;

  // Fixed payload widths
  localparam int SlotInW  = 40;
  localparam int GenInW   = 24;
  localparam int OutIdxW  = 10;
  localparam int OutGenW  = 24;
  localparam int OutCntW  = 11;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BOUNDS  = 2'd2,
    STAT_BAD_GEN = 2'd3
  } status_e;

  typedef struct packed {
    func_e                func;
    logic [SlotInW-1:0]   handle_slot;
    logic [GenInW-1:0]    handle_generation;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [OutIdxW-1:0]   new_slot;
    logic [OutGenW-1:0]   new_generation;
    logic [OutIdxW-1:0]   dense_index;
    logic                 moved;
    logic [OutIdxW-1:0]   moved_from;
    logic [OutCntW-1:0]   live_count;
  } rsp_t;

endpackage

### hdl/ght_stream_if.sv
// ----------------------------------------------------------------------------
// ght_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ght_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/ght_engine.sv
// ----------------------------------------------------------------------------
// ght_engine
// Sequencer and table memories: slot table (generation and dense index or
// free link) and reverse table (owner slot of each dense position).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "generational_handle_table_top_macros.svh"

module ght_engine #(
  parameter int SLOT_CAPACITY = ght_pkg::SlotCapacity,
  parameter int GEN_BITS      = ght_pkg::GenBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ght_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output ght_pkg::rsp_t rsp_o
);
  import ght_pkg::*;

  localparam int SW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int CW = $clog2(SLOT_CAPACITY + 1);
  localparam int EW = GEN_BITS + CW;
  localparam logic [CW-1:0]      CapC     = CW'(SLOT_CAPACITY);
  localparam logic [SW-1:0]      LastSlot = SW'(SLOT_CAPACITY - 1);
  localparam logic [SlotInW-1:0] CapIn    = SlotInW'(SLOT_CAPACITY);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ADD_FREE,
    ST_CHK_GEN,
    ST_CHK_REV,
    ST_MOVE_REV,
    ST_MOVE_SLOT,
    ST_DONE
  } state_e;

  // Resize a slot or dense index to the output index width
  function automatic logic [OutIdxW-1:0] idx_out(input logic [SW-1:0] v);
    logic [SW+OutIdxW-1:0] t;
    t = {{OutIdxW{1'b0}}, v};
    return t[OutIdxW-1:0];
  endfunction

  function automatic logic [OutCntW-1:0] cnt_out(input logic [CW-1:0] v);
    logic [CW+OutCntW-1:0] t;
    t = {{OutCntW{1'b0}}, v};
    return t[OutCntW-1:0];
  endfunction

  // Memories
  logic [EW-1:0] slot_mem [0:SLOT_CAPACITY-1];
  logic [SW-1:0] rev_mem  [0:SLOT_CAPACITY-1];
  logic [EW-1:0] slot_rdata_q;
  logic [SW-1:0] rev_rdata_q;

  logic          slot_we, slot_re, rev_we, rev_re;
  logic [SW-1:0] slot_wa, slot_ra, rev_wa, rev_ra;
  logic [EW-1:0] slot_wd;
  logic [SW-1:0] rev_wd;

  // Control and working registers
  state_e              state_q, state_d;
  req_t                req_q, req_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       free_q, free_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [SW-1:0]       dense_q, dense_d;
  logic [GEN_BITS-1:0] gen_q, gen_d;
  logic [SW-1:0]       init_q, init_d;
  rsp_t                res_q, res_d;

  logic [GEN_BITS-1:0] rd_gen;
  logic [CW-1:0]       rd_low;
  logic [CW-1:0]       last;
  logic                rsp_move_ok;

  assign rd_gen = slot_rdata_q[EW-1:CW];
  assign rd_low = slot_rdata_q[CW-1:0];
  assign last   = count_q - CW'(1);

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = res_q;

  // Sequence one request through read, check and write-back steps
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    count_d = count_q;
    free_d  = free_q;
    slot_d  = slot_q;
    dense_d = dense_q;
    gen_d   = gen_q;
    init_d  = init_q;
    res_d   = res_q;
    slot_we = 1'b0;
    slot_wa = slot_q;
    slot_wd = '0;
    slot_re = 1'b0;
    slot_ra = slot_q;
    rev_we  = 1'b0;
    rev_wa  = dense_q;
    rev_wd  = slot_q;
    rev_re  = 1'b0;
    rev_ra  = dense_q;

    case (state_q)
      // Clear both tables one entry per cycle
      ST_INIT: begin
        slot_we = 1'b1;
        slot_wa = init_q;
        slot_wd = '0;
        rev_we  = 1'b1;
        rev_wa  = init_q;
        rev_wd  = '0;
        init_d  = init_q + SW'(1);
        if (init_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_d = '0;
        case (req_q.func)
          FUNC_ADD: begin
            if (count_q >= CapC) begin
              res_d.status = STAT_FULL;
              state_d      = ST_DONE;
            end else if (free_q < CapC) begin
              // Reuse the head of the free list
              slot_re = 1'b1;
              slot_ra = free_q[SW-1:0];
              slot_d  = free_q[SW-1:0];
              state_d = ST_ADD_FREE;
            end else begin
              // Take the next fresh slot at generation zero
              slot_we = 1'b1;
              slot_wa = count_q[SW-1:0];
              slot_wd = {{GEN_BITS{1'b0}}, count_q};
              rev_we  = 1'b1;
              rev_wa  = count_q[SW-1:0];
              rev_wd  = count_q[SW-1:0];
              res_d.status      = STAT_OK;
              res_d.new_slot    = idx_out(count_q[SW-1:0]);
              res_d.dense_index = idx_out(count_q[SW-1:0]);
              count_d = count_q + CW'(1);
              state_d = ST_DONE;
            end
          end
          FUNC_REMOVE, FUNC_GET: begin
            if (req_q.handle_slot >= CapIn) begin
              res_d.status = STAT_BOUNDS;
              state_d      = ST_DONE;
            end else begin
              slot_re = 1'b1;
              slot_ra = req_q.handle_slot[SW-1:0];
              slot_d  = req_q.handle_slot[SW-1:0];
              state_d = ST_CHK_GEN;
            end
          end
          FUNC_CLEAR: begin
            count_d      = '0;
            free_d       = CapC;
            res_d.status = STAT_OK;
            state_d      = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // Pop the free list and record the element at the dense end
      ST_ADD_FREE: begin
        free_d  = (rd_low > CapC) ? CapC : rd_low;
        slot_we = 1'b1;
        slot_wa = slot_q;
        slot_wd = {rd_gen, count_q};
        rev_we  = 1'b1;
        rev_wa  = count_q[SW-1:0];
        rev_wd  = slot_q;
        res_d.status         = STAT_OK;
        res_d.new_slot       = idx_out(slot_q);
        res_d.new_generation = OutGenW'(rd_gen);
        res_d.dense_index    = idx_out(count_q[SW-1:0]);
        count_d = count_q + CW'(1);
        state_d = ST_DONE;
      end

      // Match generation and check the dense index is live
      ST_CHK_GEN: begin
        if ((GenInW'(rd_gen) != req_q.handle_generation) || (rd_low >= count_q)) begin
          res_d.status = STAT_BAD_GEN;
          state_d      = ST_DONE;
        end else begin
          rev_re  = 1'b1;
          rev_ra  = rd_low[SW-1:0];
          dense_d = rd_low[SW-1:0];
          gen_d   = rd_gen;
          state_d = ST_CHK_REV;
        end
      end

      // Confirm the reverse link, then retire the slot on remove
      ST_CHK_REV: begin
        if (rev_rdata_q != slot_q) begin
          res_d.status = STAT_BAD_GEN;
          state_d      = ST_DONE;
        end else if (req_q.func == FUNC_GET) begin
          res_d.status      = STAT_OK;
          res_d.dense_index = idx_out(dense_q);
          state_d           = ST_DONE;
        end else begin
          slot_we = 1'b1;
          slot_wa = slot_q;
          slot_wd = {gen_q + GEN_BITS'(1), free_q};
          free_d  = CW'(slot_q);
          res_d.status      = STAT_OK;
          res_d.dense_index = idx_out(dense_q);
          if (CW'(dense_q) != last) begin
            rev_re  = 1'b1;
            rev_ra  = last[SW-1:0];
            state_d = ST_MOVE_REV;
          end else begin
            count_d = last;
            state_d = ST_DONE;
          end
        end
      end

      // Fetch the slot entry of the last dense element
      ST_MOVE_REV: begin
        slot_re = 1'b1;
        slot_ra = rev_rdata_q;
        slot_d  = rev_rdata_q;
        state_d = ST_MOVE_SLOT;
      end

      // Move the last element into the hole
      ST_MOVE_SLOT: begin
        slot_we = 1'b1;
        slot_wa = slot_q;
        slot_wd = {rd_gen, CW'(dense_q)};
        rev_we  = 1'b1;
        rev_wa  = dense_q;
        rev_wd  = slot_q;
        res_d.moved      = 1'b1;
        res_d.moved_from = idx_out(last[SW-1:0]);
        count_d = last;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Report the count left behind by this request
    if ((state_d == ST_DONE) && (state_q != ST_DONE)) begin
      res_d.live_count = cnt_out(count_d);
    end
  end

  // State and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      req_q   <= '0;
      count_q <= '0;
      free_q  <= CapC;
      slot_q  <= '0;
      dense_q <= '0;
      gen_q   <= '0;
      init_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      count_q <= count_d;
      free_q  <= free_d;
      slot_q  <= slot_d;
      dense_q <= dense_d;
      gen_q   <= gen_d;
      init_q  <= init_d;
      res_q   <= res_d;
    end
  end

  // Table memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rdata_q <= slot_mem[slot_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rev_we) begin
      rev_mem[rev_wa] <= rev_wd;
    end
    if (rev_re) begin
      rev_rdata_q <= rev_mem[rev_ra];
    end
  end

  // Checks
  assign rsp_move_ok = (rsp_o.status == STAT_OK) && (rsp_o.dense_index != rsp_o.moved_from);

  `GHT_ASSERT(a_count_range, count_q <= CapC, "live count above capacity")
  `GHT_ASSERT(a_free_range, free_q <= CapC, "free head out of range")
  `GHT_ASSERT_NEXT(a_move_cnt, state_q == ST_MOVE_SLOT, count_q == $past(last), "move kept count")
  `GHT_ASSERT(a_move_ok, !(rsp_valid_o && rsp_o.moved) || rsp_move_ok, "move on a bad result")

endmodule

### hdl/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Slot map handle table: add, remove, get and clear over generational handles.
// ----------------------------------------------------------------------------
//   channel  dir  modport  payload
//   req_i    in   sink     ght_pkg::req_t (func, handle_slot, handle_generation)
//   rsp_o    out  source   ght_pkg::rsp_t (status .. live_count)
//
// After reset a clearing pass zeroes the tables; no request is taken until it
// ends.
// Clear, full add, out-of-bounds handles and fresh-slot add go from decode straight
// to the result; add from the free list reads the slot first; get reads the slot
// and reverse tables (a wrong generation ends after the slot read); remove chains
// slot, reverse and moved slot reads, two of them on the single slot table read port.
// The result register lets a new request in while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table_top #(
  parameter int SLOT_CAPACITY = ght_pkg::SlotCapacity,
  parameter int GEN_BITS      = ght_pkg::GenBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ght_stream_if.sink        req_i,
  ght_stream_if.source      rsp_o
);
  import ght_pkg::*;

  logic eng_rsp_valid;
  logic eng_rsp_ready;
  rsp_t eng_rsp;
  logic out_valid_q;
  rsp_t out_q;

  ght_engine #(
    .SLOT_CAPACITY (SLOT_CAPACITY),
    .GEN_BITS      (GEN_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .rsp_valid_o (eng_rsp_valid),
    .rsp_ready_i (eng_rsp_ready),
    .rsp_o       (eng_rsp)
  );

  // Take a result when the output register is empty or being drained
  assign eng_rsp_ready = !out_valid_q || rsp_o.ready;

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_rsp_ready) begin
      out_valid_q <= eng_rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_rsp_ready && eng_rsp_valid) begin
      out_q <= eng_rsp;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule
